// ===== hw/rtl/utf8d_pkg.sv =====
// Shared types and constants for the UTF-8 sequence decoder.
`timescale 1ns / 1ps

package utf8d_pkg;

	localparam int unsigned CpWidth  = 31;
	localparam int unsigned StWidth  = 3;
	localparam int unsigned LenWidth = 3;

	localparam logic [StWidth-1:0] ST_OK        = 3'd0;
	localparam logic [StWidth-1:0] ST_BAD_LEAD  = 3'd1;
	localparam logic [StWidth-1:0] ST_TRUNC     = 3'd2;
	localparam logic [StWidth-1:0] ST_SURROGATE = 3'd3;
	localparam logic [StWidth-1:0] ST_NONCHAR   = 3'd4;
	localparam logic [StWidth-1:0] ST_HIGH      = 3'd5;

	localparam logic [CpWidth-1:0] SurrogateLo = 31'h0000_D800;
	localparam logic [CpWidth-1:0] SurrogateHi = 31'h0000_DFFF;
	localparam logic [CpWidth-1:0] NoncharLo   = 31'h0000_FFFE;
	localparam logic [CpWidth-1:0] NoncharHi   = 31'h0000_FFFF;
	localparam logic [CpWidth-1:0] MaxScalar   = 31'h0010_FFFF;

	typedef struct packed {
		logic [7:0] lead_byte;
		logic [7:0] second_byte;
		logic [7:0] third_byte;
		logic [7:0] fourth_byte;
		logic [7:0] fifth_byte;
		logic [7:0] sixth_byte;
	} window_t;

	typedef struct packed {
		logic [CpWidth-1:0]  codepoint;
		logic [StWidth-1:0]  status;
		logic [LenWidth-1:0] seq_length;
	} result_t;

endpackage

// ===== hw/rtl/utf8d_decode.sv =====
// Combinational decode of one six-byte window into a codepoint, status and length.
`timescale 1ns / 1ps

module utf8d_decode (
	input  utf8d_pkg::window_t win,
	output utf8d_pkg::result_t res
);

	logic [utf8d_pkg::LenWidth-1:0] len;
	logic [4:0]                     cont_ok;
	logic [utf8d_pkg::CpWidth-1:0]  val;
	logic                           trunc;

	// continuation byte checks for bytes two to six
	assign cont_ok[0] = (win.second_byte[7:6] == 2'b10);
	assign cont_ok[1] = (win.third_byte[7:6]  == 2'b10);
	assign cont_ok[2] = (win.fourth_byte[7:6] == 2'b10);
	assign cont_ok[3] = (win.fifth_byte[7:6]  == 2'b10);
	assign cont_ok[4] = (win.sixth_byte[7:6]  == 2'b10);

	always_comb begin
		casez (win.lead_byte)
			8'b0???????: len = 3'd1;
			8'b110?????: len = 3'd2;
			8'b1110????: len = 3'd3;
			8'b11110???: len = 3'd4;
			8'b111110??: len = 3'd5;
			8'b1111110?: len = 3'd6;
			default:     len = 3'd0;
		endcase
	end

	// strip the lead's length bits and pack the six-bit payloads
	always_comb begin
		case (len)
			3'd1: begin
				val   = {23'd0, win.lead_byte};
				trunc = 1'b0;
			end
			3'd2: begin
				val   = {20'd0, win.lead_byte[4:0], win.second_byte[5:0]};
				trunc = !cont_ok[0];
			end
			3'd3: begin
				val   = {15'd0, win.lead_byte[3:0], win.second_byte[5:0],
					win.third_byte[5:0]};
				trunc = !(&cont_ok[1:0]);
			end
			3'd4: begin
				val   = {10'd0, win.lead_byte[2:0], win.second_byte[5:0],
					win.third_byte[5:0], win.fourth_byte[5:0]};
				trunc = !(&cont_ok[2:0]);
			end
			3'd5: begin
				val   = {5'd0, win.lead_byte[1:0], win.second_byte[5:0],
					win.third_byte[5:0], win.fourth_byte[5:0], win.fifth_byte[5:0]};
				trunc = !(&cont_ok[3:0]);
			end
			3'd6: begin
				val   = {win.lead_byte[0], win.second_byte[5:0], win.third_byte[5:0],
					win.fourth_byte[5:0], win.fifth_byte[5:0], win.sixth_byte[5:0]};
				trunc = !(&cont_ok);
			end
			default: begin
				val   = '0;
				trunc = 1'b0;
			end
		endcase
	end

	// error priority: bad lead, truncated, surrogate, noncharacter, too high
	always_comb begin
		res.seq_length = len;
		res.codepoint  = '0;
		if (len == 3'd0) begin
			res.status = utf8d_pkg::ST_BAD_LEAD;
		end else if (trunc) begin
			res.status = utf8d_pkg::ST_TRUNC;
		end else if (val >= utf8d_pkg::SurrogateLo && val <= utf8d_pkg::SurrogateHi) begin
			res.status = utf8d_pkg::ST_SURROGATE;
		end else if (val == utf8d_pkg::NoncharLo || val == utf8d_pkg::NoncharHi) begin
			res.status = utf8d_pkg::ST_NONCHAR;
		end else if (val > utf8d_pkg::MaxScalar) begin
			res.status = utf8d_pkg::ST_HIGH;
		end else begin
			res.status    = utf8d_pkg::ST_OK;
			res.codepoint = val;
		end
	end

endmodule

// ===== hw/rtl/utf8_sequence_decoder.sv =====
// Top level of the UTF-8 sequence decoder: input register, decode, result register.
//
//   channel   direction  handshake          payload
//   command   in         start & !busy      lead_byte .. sixth_byte (8 bits each)
//   result    out        done (one cycle)   codepoint[30:0], status[2:0], seq_length[2:0]
//
// One beat is taken per clock; busy is never raised, so start may be held high
// continuously. A result passes through the input register and then the result
// register before it appears on done.
// The receiver cannot stall: each result is shown for exactly one cycle.
// arst_n clears both valid flags; the payload registers are not reset.
`timescale 1ns / 1ps

module utf8_sequence_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  lead_byte,
	input  logic [7:0]  second_byte,
	input  logic [7:0]  third_byte,
	input  logic [7:0]  fourth_byte,
	input  logic [7:0]  fifth_byte,
	input  logic [7:0]  sixth_byte,
	output logic        done,
	output logic [30:0] codepoint,
	output logic [2:0]  status,
	output logic [2:0]  seq_length
);

	utf8d_pkg::window_t win_s1;
	logic               valid_s1;
	utf8d_pkg::result_t res_comb;
	utf8d_pkg::result_t res_s2;
	logic               valid_s2;

	// the decode is a single shallow pass, so a beat is always welcome
	assign busy = 1'b0;

	// stage 1: capture the window on a command beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			win_s1 <= '{lead_byte, second_byte, third_byte,
				fourth_byte, fifth_byte, sixth_byte};
		end
	end

	utf8d_decode u_decode (
		.win (win_s1),
		.res (res_comb)
	);

	// stage 2: hold the decoded result for its single strobe cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign done       = valid_s2;
	assign codepoint  = res_s2.codepoint;
	assign status     = res_s2.status;
	assign seq_length = res_s2.seq_length;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the UTF-8 sequence decoder.
`timescale 1ns / 1ps

module testbench;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [7:0]                    lead_byte;
	logic [7:0]                    second_byte;
	logic [7:0]                    third_byte;
	logic [7:0]                    fourth_byte;
	logic [7:0]                    fifth_byte;
	logic [7:0]                    sixth_byte;
	logic                          done;
	logic [utf8d_pkg::CpWidth-1:0] codepoint;
	logic [utf8d_pkg::StWidth-1:0] status;
	logic [2:0]                    seq_length;

	// Decoded results still owed by the block, oldest first.
	utf8d_pkg::result_t pending_decodes[$];
	int unsigned        mismatch_count;
	int unsigned        sender_idle_pct;

	utf8_sequence_decoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.lead_byte  (lead_byte),
		.second_byte(second_byte),
		.third_byte (third_byte),
		.fourth_byte(fourth_byte),
		.fifth_byte (fifth_byte),
		.sixth_byte (sixth_byte),
		.done       (done),
		.codepoint  (codepoint),
		.status     (status),
		.seq_length (seq_length)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop: ample for the whole run.
	initial begin
		#200000;
		$display("utf8_sequence_decoder regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Decode one six-byte window: length from the lead byte, mask the lead's
	// length bits, shift in six bits per continuation, then range checks in
	// the order surrogate, noncharacter, above the scalar limit.
	function automatic utf8d_pkg::result_t decode_window(input utf8d_pkg::window_t w);
		logic [7:0]         b [6];
		int unsigned        n;
		int unsigned        i;
		logic [31:0]        acc;
		utf8d_pkg::result_t r;
		b = '{w.lead_byte, w.second_byte, w.third_byte,
		      w.fourth_byte, w.fifth_byte, w.sixth_byte};
		r = '0;
		casez (b[0])
			8'b0???????: n = 1;
			8'b110?????: n = 2;
			8'b1110????: n = 3;
			8'b11110???: n = 4;
			8'b111110??: n = 5;
			8'b1111110?: n = 6;
			default:     n = 0;
		endcase
		if (n == 0) begin
			r.status = utf8d_pkg::ST_BAD_LEAD;
			return r;
		end
		r.seq_length = n[2:0];
		if (n == 1) begin
			r.codepoint = {24'd0, b[0][6:0]};
			r.status    = utf8d_pkg::ST_OK;
			return r;
		end
		acc = {24'd0, b[0]} & ((32'd1 << (7 - n)) - 32'd1);
		for (i = 1; i < n; i++) begin
			// A byte that is not 10xxxxxx ends the decode early.
			if (b[i][7:6] != 2'b10) begin
				r.status = utf8d_pkg::ST_TRUNC;
				return r;
			end
			acc = (acc << 6) | {26'd0, b[i][5:0]};
		end
		if (acc >= utf8d_pkg::SurrogateLo && acc <= utf8d_pkg::SurrogateHi)
			r.status = utf8d_pkg::ST_SURROGATE;
		else if (acc == utf8d_pkg::NoncharLo || acc == utf8d_pkg::NoncharHi)
			r.status = utf8d_pkg::ST_NONCHAR;
		else if (acc > utf8d_pkg::MaxScalar)
			r.status = utf8d_pkg::ST_HIGH;
		else begin
			r.status    = utf8d_pkg::ST_OK;
			r.codepoint = acc[utf8d_pkg::CpWidth-1:0];
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Encode a value as an n-byte sequence; bytes past the sequence are random
	// so that the ignored tail is exercised too. Value bits that do not fit
	// the form are dropped.
	function automatic utf8d_pkg::window_t encode_scalar(input logic [30:0] cp,
			input int unsigned n);
		logic [7:0]  b [6];
		logic [7:0]  prefix;
		logic [7:0]  lead_mask;
		logic [30:0] shifted;
		int unsigned i;
		for (i = 0; i < 6; i++)
			b[i] = 8'($urandom);
		if (n == 1)
			b[0] = {1'b0, cp[6:0]};
		else begin
			prefix    = 8'hFF << (8 - n);
			lead_mask = (8'd1 << (7 - n)) - 8'd1;
			shifted   = cp >> (6 * (n - 1));
			b[0]      = prefix | (shifted[7:0] & lead_mask);
			for (i = 1; i < n; i++) begin
				shifted = cp >> (6 * (n - 1 - i));
				b[i]    = {2'b10, shifted[5:0]};
			end
		end
		return {b[0], b[1], b[2], b[3], b[4], b[5]};
	endfunction

	// Overwrite byte idx (0 is the lead) of a window.
	function automatic utf8d_pkg::window_t break_at(input utf8d_pkg::window_t w,
			input int unsigned idx, input logic [7:0] bad);
		logic [47:0] flat;
		flat = w;
		flat[47 - 8 * idx -: 8] = bad;
		return flat;
	endfunction

	// A window with a chosen lead byte and a random tail.
	function automatic utf8d_pkg::window_t with_lead(input logic [7:0] lead);
		return {lead, 8'($urandom), 32'($urandom)};
	endfunction

	// Pick a value that suits an n-byte form, steering some picks onto the
	// surrogate block, the noncharacters and the scalar limit.
	function automatic logic [30:0] pick_scalar(input int unsigned n);
		int unsigned sel;
		logic [31:0] cp;
		sel = $urandom_range(9);
		if (sel == 0 && n >= 3)
			cp = 32'h0000_D7FE + $urandom_range(0, 32'h803);
		else if (sel == 1 && n >= 3)
			cp = 32'h0000_FFFC + $urandom_range(0, 5);
		else if (sel == 2 && n >= 4)
			cp = 32'h0010_FFF0 + $urandom_range(0, 32'h1F);
		else if (n == 1)
			cp = $urandom_range(0, 32'h7F);
		else
			cp = $urandom & ((32'd1 << (5 * n + 1)) - 32'd1);
		return cp[30:0];
	endfunction

	// Drive one command beat, with random idle cycles ahead of it, and log
	// the expected decode once the beat is taken. Start stays high between
	// back-to-back beats.
	task automatic send_window(input utf8d_pkg::window_t w);
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start       <= 1'b1;
		lead_byte   <= w.lead_byte;
		second_byte <= w.second_byte;
		third_byte  <= w.third_byte;
		fourth_byte <= w.fourth_byte;
		fifth_byte  <= w.fifth_byte;
		sixth_byte  <= w.sixth_byte;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_decodes.push_back(decode_window(w));
	endtask

	// Drop start and hold until every owed result has come back.
	task automatic wait_drained;
		@(negedge clk);
		start <= 1'b0;
		while (pending_decodes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// Result checking: each done beat against the oldest expectation
	// ------------------------------------------------------------------

	always @(posedge clk) begin : check_result
		utf8d_pkg::result_t want;
		if (arst_n && done) begin
			if (pending_decodes.size() == 0)
				report_mismatch("result beat with nothing expected");
			else begin
				want = pending_decodes.pop_front();
				if (codepoint !== want.codepoint)
					report_mismatch($sformatf("codepoint %h, expected %h",
						codepoint, want.codepoint));
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						status, want.status));
				if (seq_length !== want.seq_length)
					report_mismatch($sformatf("seq_length %0d, expected %0d",
						seq_length, want.seq_length));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Single byte: both ends of the ASCII range pass straight through.
	task automatic test_ascii;
		send_window(with_lead(8'h00));
		send_window(with_lead(8'h7F));
	endtask

	// Continuation bytes and 0xFE/0xFF cannot start a sequence.
	task automatic test_bad_lead;
		send_window(with_lead(8'h80));
		send_window(with_lead(8'hBF));
		send_window(with_lead(8'hFE));
		send_window(with_lead(8'hFF));
	endtask

	// Well-formed sequences at the edges of their forms.
	task automatic test_valid_forms;
		send_window(encode_scalar(31'h7FF, 2));
		send_window(encode_scalar(31'hFFFD, 3));
		send_window(encode_scalar(31'h1_0000, 4));
		send_window(encode_scalar(31'h10_FFFF, 4));
	endtask

	// Overlong encodings, the 0xC0/0xC1 leads among them, decode as usual.
	task automatic test_overlong;
		send_window(encode_scalar(31'h0, 2));
		send_window(encode_scalar(31'h7F, 2));
		send_window(encode_scalar(31'h0, 6));
	endtask

	// A bad continuation at the first, a middle and the last position.
	task automatic test_truncation;
		send_window(break_at(encode_scalar(31'h123, 2), 1, 8'h7F));
		send_window(break_at(encode_scalar(31'h1234, 3), 1, 8'hFF));
		send_window(break_at(encode_scalar(31'h1_2345, 4), 2, 8'hC0));
		send_window(break_at(encode_scalar(31'h0123_4567, 6), 5, 8'h00));
	endtask

	// Value range rejections: surrogates, noncharacters, above the limit.
	task automatic test_value_checks;
		send_window(encode_scalar(31'hD800, 3));
		send_window(encode_scalar(31'hDFFF, 4));
		send_window(encode_scalar(31'hFFFE, 3));
		send_window(encode_scalar(31'hFFFF, 5));
		send_window(encode_scalar(31'h11_0000, 4));
		send_window(encode_scalar(31'h3FF_FFFF, 5));
		send_window(encode_scalar(31'h7FFF_FFFF, 6));
	endtask

	// Mostly well-formed sequences with random content, the rest broken
	// sequences and raw noise with random values on every input bit.
	task automatic run_random_phase(input int unsigned count, input int unsigned idle_pct);
		int unsigned        k;
		int unsigned        kind;
		int unsigned        n;
		logic [7:0]         bad;
		utf8d_pkg::window_t w;
		sender_idle_pct = idle_pct;
		for (k = 0; k < count; k++) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				n = $urandom_range(1, 6);
				w = encode_scalar(pick_scalar(n), n);
			end else if (kind < 85) begin
				n   = $urandom_range(2, 6);
				bad = 8'($urandom);
				while (bad[7:6] == 2'b10)
					bad = 8'($urandom);
				w = break_at(encode_scalar(31'($urandom), n), $urandom_range(1, n - 1), bad);
			end else
				w = {16'($urandom), 32'($urandom)};
			send_window(w);
		end
	endtask

	task automatic test_random;
		run_random_phase(400, 0);
		run_random_phase(400, 57);
		// Let the pipe empty completely before carrying on.
		wait_drained();
		run_random_phase(400, 0);
		run_random_phase(400, 16);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		mismatch_count  = 0;
		sender_idle_pct = 0;
		arst_n          = 1'b0;
		start           = 1'b0;
		lead_byte       = 8'h00;
		second_byte     = 8'h00;
		third_byte      = 8'h00;
		fourth_byte     = 8'h00;
		fifth_byte      = 8'h00;
		sixth_byte      = 8'h00;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_ascii();
		test_bad_lead();
		test_valid_forms();
		test_overlong();
		test_truncation();
		test_value_checks();
		test_random();

		// Drain, then allow a little slack for strays.
		wait_drained();
		if (mismatch_count == 0)
			$display("utf8_sequence_decoder regression: pass");
		else
			$display("utf8_sequence_decoder regression: fail");
		$finish;
	end

endmodule

// ===== utf8_sequence_decoder.f =====
hw/rtl/utf8d_pkg.sv
hw/rtl/utf8d_decode.sv
hw/rtl/utf8_sequence_decoder.sv
tb/testbench.sv
